FILE: rtl/core/xmodem_checksum_receiver_top_macros.svh
// Assertion macros used by the XMODEM receiver checker.
`ifndef XMODEM_CHECKSUM_RECEIVER_TOP_MACROS_SVH
`define XMODEM_CHECKSUM_RECEIVER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define XCR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define XCR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/xcr_pkg.sv
// Shared types and constants of the XMODEM checksum receiver.
`default_nettype none
package xcr_pkg;

  localparam int unsigned ADDR_W      = 24;
  localparam int unsigned BLOCK_BYTES = 128;
  localparam int unsigned IDX_W       = $clog2(BLOCK_BYTES);

  localparam logic [ADDR_W-1:0] NAK_INTERVAL_RST = 24'd2000000;

  localparam logic [7:0] CODE_SOH = 8'h01;
  localparam logic [7:0] CODE_EOT = 8'h04;
  localparam logic [7:0] CODE_ACK = 8'h06;
  localparam logic [7:0] CODE_NAK = 8'h15;
  localparam logic [7:0] CODE_CAN = 8'h18;
  localparam logic [7:0] INV_MASK = 8'hff;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_BYTE    = 2'd1,
    OP_RESTART = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_RUNNING   = 2'd0,
    ST_EOT       = 2'd1,
    ST_CANCELLED = 2'd2,
    ST_ERROR     = 2'd3
  } status_t;

  typedef enum logic [5:0] {
    PH_HEADER  = 6'b000001,
    PH_NUMBER  = 6'b000010,
    PH_INVERSE = 6'b000100,
    PH_DATA    = 6'b001000,
    PH_CHECK   = 6'b010000,
    PH_DONE    = 6'b100000
  } phase_t;

endpackage
`default_nettype wire

FILE: rtl/core/xcr_ifs.sv
// Handshake channel interfaces of the XMODEM checksum receiver.
`default_nettype none

interface xcr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] rx_byte;
  modport source (output valid, op, rx_byte, input ready);
  modport sink   (input valid, op, rx_byte, output ready);
endinterface

interface xcr_out_if;
  logic        valid;
  logic        ready;
  logic        send_valid;
  logic [7:0]  send_byte;
  logic        write_valid;
  logic [23:0] write_addr;
  logic [7:0]  write_data;
  logic [1:0]  status;
  logic [23:0] size_total;
  modport source (output valid, send_valid, send_byte, write_valid, write_addr,
                  write_data, status, size_total, input ready);
  modport sink   (input valid, send_valid, send_byte, write_valid, write_addr,
                  write_data, status, size_total, output ready);
endinterface

interface xcr_cfg_if;
  logic        valid;
  logic        ready;
  logic [23:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/xmodem_checksum_receiver_top.sv
// XMODEM checksum receiver: protocol state machine with a registered result word.
`default_nettype none
// Takes one input word per cycle (tick, received byte or restart) and answers
// each with exactly one result word from its output register, in the cycle after
// acceptance. The whole protocol update is a single pass of logic between the
// state registers and the output register, so the rate is one word per cycle;
// in_ch.ready only drops while a result word sits unclaimed in the output
// register and out_ch.ready is low. The NAK interval is written on cfg_ch,
// which is always ready, and must only change while the block is idle.
module xmodem_checksum_receiver_top
  import xcr_pkg::*;
(
  input  wire        clk,
  input  wire        rst_n,
  xcr_in_if.sink     in_ch,
  xcr_out_if.source  out_ch,
  xcr_cfg_if.sink    cfg_ch
);

  logic [ADDR_W-1:0] nak_interval_r;

  phase_t            phase_r, phase_nxt;
  logic              started_r, started_nxt;
  logic [7:0]        exp_block_r, exp_block_nxt;
  logic [IDX_W-1:0]  byte_idx_r, byte_idx_nxt;
  logic [7:0]        sum_r, sum_nxt;
  logic [ADDR_W-1:0] tick_cnt_r, tick_cnt_nxt;
  logic [ADDR_W-1:0] acc_size_r, acc_size_nxt;
  status_t           status_r, status_nxt;

  logic              out_valid_r;
  logic              snd_v_r, snd_v_nxt;
  logic [7:0]        snd_b_r, snd_b_nxt;
  logic              wr_v_r, wr_v_nxt;
  logic [ADDR_W-1:0] wr_a_r, wr_a_nxt;
  logic [7:0]        wr_d_r, wr_d_nxt;

  logic              in_fire;
  logic [ADDR_W-1:0] tick_inc;

  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign tick_inc     = tick_cnt_r + ADDR_W'(1);

  always_comb begin
    phase_nxt     = phase_r;
    started_nxt   = started_r;
    exp_block_nxt = exp_block_r;
    byte_idx_nxt  = byte_idx_r;
    sum_nxt       = sum_r;
    tick_cnt_nxt  = tick_cnt_r;
    acc_size_nxt  = acc_size_r;
    status_nxt    = status_r;
    snd_v_nxt     = 1'b0;
    snd_b_nxt     = 8'h00;
    wr_v_nxt      = 1'b0;
    wr_a_nxt      = '0;
    wr_d_nxt      = 8'h00;
    unique case (op_t'(in_ch.op))
      OP_RESTART: begin
        phase_nxt     = PH_HEADER;
        started_nxt   = 1'b0;
        exp_block_nxt = 8'd1;
        byte_idx_nxt  = '0;
        sum_nxt       = 8'h00;
        tick_cnt_nxt  = '0;
        acc_size_nxt  = '0;
        status_nxt    = ST_RUNNING;
      end
      OP_TICK: begin
        // Start requests only go out before the first block header.
        if (phase_r == PH_HEADER && !started_r) begin
          if (tick_inc >= nak_interval_r) begin
            tick_cnt_nxt = '0;
            snd_v_nxt    = 1'b1;
            snd_b_nxt    = CODE_NAK;
          end else begin
            tick_cnt_nxt = tick_inc;
          end
        end
      end
      OP_BYTE: begin
        unique case (phase_r)
          PH_HEADER: begin
            tick_cnt_nxt = '0;
            if (in_ch.rx_byte == CODE_EOT) begin
              snd_v_nxt  = 1'b1;
              snd_b_nxt  = CODE_ACK;
              status_nxt = ST_EOT;
              phase_nxt  = PH_DONE;
            end else if (in_ch.rx_byte == CODE_CAN) begin
              status_nxt = ST_CANCELLED;
              phase_nxt  = PH_DONE;
            end else if (in_ch.rx_byte == CODE_SOH) begin
              started_nxt = 1'b1;
              phase_nxt   = PH_NUMBER;
            end else if (started_r) begin
              status_nxt = ST_ERROR;
              phase_nxt  = PH_DONE;
            end
          end
          PH_NUMBER: begin
            if (in_ch.rx_byte != exp_block_r) begin
              snd_v_nxt = 1'b1;
              snd_b_nxt = CODE_NAK;
              phase_nxt = PH_HEADER;
            end else begin
              phase_nxt = PH_INVERSE;
            end
          end
          PH_INVERSE: begin
            if ((exp_block_r ^ in_ch.rx_byte) != INV_MASK) begin
              snd_v_nxt = 1'b1;
              snd_b_nxt = CODE_NAK;
              phase_nxt = PH_HEADER;
            end else begin
              byte_idx_nxt = '0;
              sum_nxt      = 8'h00;
              phase_nxt    = PH_DATA;
            end
          end
          PH_DATA: begin
            wr_v_nxt = 1'b1;
            wr_a_nxt = acc_size_r + ADDR_W'(byte_idx_r);
            wr_d_nxt = in_ch.rx_byte;
            sum_nxt  = sum_r + in_ch.rx_byte;
            byte_idx_nxt = byte_idx_r + IDX_W'(1);
            if (byte_idx_r == IDX_W'(BLOCK_BYTES - 1)) begin
              phase_nxt = PH_CHECK;
            end
          end
          PH_CHECK: begin
            snd_v_nxt = 1'b1;
            if (sum_r != in_ch.rx_byte) begin
              snd_b_nxt = CODE_NAK;
            end else begin
              snd_b_nxt     = CODE_ACK;
              acc_size_nxt  = acc_size_r + ADDR_W'(BLOCK_BYTES);
              exp_block_nxt = exp_block_r + 8'd1;
            end
            phase_nxt = PH_HEADER;
          end
          PH_DONE: begin
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nak_interval_r <= NAK_INTERVAL_RST;
    end else if (cfg_ch.valid) begin
      nak_interval_r <= cfg_ch.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HEADER;
      started_r   <= 1'b0;
      exp_block_r <= 8'd1;
      byte_idx_r  <= '0;
      sum_r       <= 8'h00;
      tick_cnt_r  <= '0;
      acc_size_r  <= '0;
      status_r    <= ST_RUNNING;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        phase_r     <= phase_nxt;
        started_r   <= started_nxt;
        exp_block_r <= exp_block_nxt;
        byte_idx_r  <= byte_idx_nxt;
        sum_r       <= sum_nxt;
        tick_cnt_r  <= tick_cnt_nxt;
        acc_size_r  <= acc_size_nxt;
        status_r    <= status_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result word payload; the status and size are taken from the next state.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      snd_v_r <= snd_v_nxt;
      snd_b_r <= snd_b_nxt;
      wr_v_r  <= wr_v_nxt;
      wr_a_r  <= wr_a_nxt;
      wr_d_r  <= wr_d_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.send_valid  = snd_v_r;
  assign out_ch.send_byte   = snd_b_r;
  assign out_ch.write_valid = wr_v_r;
  assign out_ch.write_addr  = wr_a_r;
  assign out_ch.write_data  = wr_d_r;
  assign out_ch.status      = status_r;
  assign out_ch.size_total  = acc_size_r;

endmodule
`default_nettype wire

FILE: rtl/core/xcr_checker.sv
// Port-level assertion checker for the XMODEM checksum receiver, with its bind.
`default_nettype none
`include "xmodem_checksum_receiver_top_macros.svh"
module xcr_checker
  import xcr_pkg::*;
(
  input wire        clk,
  input wire        rst_n,
  input wire        out_valid,
  input wire        out_ready,
  input wire        send_valid,
  input wire [7:0]  send_byte,
  input wire        write_valid,
  input wire [23:0] write_addr,
  input wire [7:0]  write_data,
  input wire [1:0]  status,
  input wire [23:0] size_total
);

  `XCR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                   out_valid && $stable({send_valid, send_byte, write_valid, write_addr,
                                         write_data, status, size_total}),
                   "result word changed while stalled")

  // A data byte is only stored mid-block: no reply goes out and the transfer runs.
  `XCR_ASSERT_NOW(a_write_excl, out_valid && write_valid,
                  !send_valid && status == ST_RUNNING,
                  "data write with reply or ended transfer")

  `XCR_ASSERT_NOW(a_send_code, out_valid && send_valid,
                  send_byte == CODE_ACK || send_byte == CODE_NAK,
                  "reply is neither ACK nor NAK")

  // Only whole blocks are ever counted as received.
  `XCR_ASSERT_NOW(a_size_align, out_valid, size_total[IDX_W-1:0] == '0,
                  "received size not a whole number of blocks")

endmodule

bind xmodem_checksum_receiver_top xcr_checker u_xcr_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .send_valid  (out_ch.send_valid),
  .send_byte   (out_ch.send_byte),
  .write_valid (out_ch.write_valid),
  .write_addr  (out_ch.write_addr),
  .write_data  (out_ch.write_data),
  .status      (out_ch.status),
  .size_total  (out_ch.size_total)
);
`default_nettype wire

FILE: tb/tb.sv
// Self-checking testbench for the XMODEM checksum receiver with a built-in protocol predictor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import xcr_pkg::*;

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam int         BLOCK_WORDS = BLOCK_BYTES + 4;  // SOH, number, inverse, data, sum
  localparam int         STALL_LIMIT = 5000;
  localparam int         MAX_REPORTS = 10;

  typedef struct packed {
    logic        send_valid;
    logic [7:0]  send_byte;
    logic        write_valid;
    logic [23:0] write_addr;
    logic [7:0]  write_data;
    logic [1:0]  status;
    logic [23:0] size_total;
  } reply_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  xcr_in_if  in_if();
  xcr_out_if out_if();
  xcr_cfg_if cfg_if();

  xmodem_checksum_receiver_top uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state, mirroring the receiver.
  logic [23:0] nak_ivl;
  phase_t      rx_phase;
  logic        rx_started;
  logic [7:0]  exp_block;
  logic [6:0]  byte_idx;
  logic [7:0]  run_sum;
  logic [23:0] tick_cnt;
  logic [23:0] acc_size;
  status_t     fin_status;

  reply_t reply_q[$];

  int err_count;
  int mismatch_cnt;
  int items_sent;
  int replies_seen;
  int ack_seen;
  int nak_seen;
  int wr_seen;
  int in_stall_cycles;
  int quiet_cycles;

  // Sender and receiver pacing.
  int burst_left;
  bit in_on;
  int hold_req;
  int hold_left;
  int stall_mode;
  int mode_left;
  int pattern_cnt;

  function automatic void clear_receiver();
    rx_phase   = PH_HEADER;
    rx_started = 1'b0;
    exp_block  = 8'd1;
    byte_idx   = '0;
    run_sum    = '0;
    tick_cnt   = '0;
    acc_size   = '0;
    fin_status = ST_RUNNING;
  endfunction

  function automatic reply_t predict_reply(input logic [1:0] op, input logic [7:0] b);
    reply_t r;
    r = '0;
    case (op)
      OP_RESTART: clear_receiver();
      OP_TICK: begin
        if (rx_phase == PH_HEADER && !rx_started) begin
          tick_cnt = tick_cnt + 24'd1;
          if (tick_cnt >= nak_ivl) begin
            tick_cnt     = '0;
            r.send_valid = 1'b1;
            r.send_byte  = CODE_NAK;
          end
        end
      end
      OP_BYTE: begin
        case (rx_phase)
          PH_HEADER: begin
            tick_cnt = '0;
            if (b == CODE_EOT) begin
              r.send_valid = 1'b1;
              r.send_byte  = CODE_ACK;
              fin_status   = ST_EOT;
              rx_phase     = PH_DONE;
            end else if (b == CODE_CAN) begin
              fin_status = ST_CANCELLED;
              rx_phase   = PH_DONE;
            end else if (b == CODE_SOH) begin
              rx_started = 1'b1;
              rx_phase   = PH_NUMBER;
            end else if (rx_started) begin
              fin_status = ST_ERROR;
              rx_phase   = PH_DONE;
            end
          end
          PH_NUMBER: begin
            if (b != exp_block) begin
              r.send_valid = 1'b1;
              r.send_byte  = CODE_NAK;
              rx_phase     = PH_HEADER;
            end else begin
              rx_phase = PH_INVERSE;
            end
          end
          PH_INVERSE: begin
            if ((exp_block ^ b) != INV_MASK) begin
              r.send_valid = 1'b1;
              r.send_byte  = CODE_NAK;
              rx_phase     = PH_HEADER;
            end else begin
              byte_idx = '0;
              run_sum  = '0;
              rx_phase = PH_DATA;
            end
          end
          PH_DATA: begin
            r.write_valid = 1'b1;
            r.write_addr  = acc_size + 24'(byte_idx);
            r.write_data  = b;
            run_sum       = run_sum + b;
            if (byte_idx == 7'(BLOCK_BYTES - 1)) begin
              byte_idx = '0;
              rx_phase = PH_CHECK;
            end else begin
              byte_idx = byte_idx + 7'd1;
            end
          end
          PH_CHECK: begin
            r.send_valid = 1'b1;
            if (run_sum != b) begin
              r.send_byte = CODE_NAK;
            end else begin
              r.send_byte = CODE_ACK;
              acc_size    = acc_size + 24'(BLOCK_BYTES);
              exp_block   = exp_block + 8'd1;
            end
            rx_phase = PH_HEADER;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    r.status     = fin_status;
    r.size_total = acc_size;
    return r;
  endfunction

  function automatic string fmt_reply(input reply_t r);
    return $sformatf("send=%0b/%02h write=%0b @%06h=%02h status=%0d size=%06h",
                     r.send_valid, r.send_byte, r.write_valid, r.write_addr,
                     r.write_data, r.status, r.size_total);
  endfunction

  // Sends one word; the sender runs in bursts with random gaps between them.
  task automatic send_word(input logic [1:0] op, input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        if (in_on) begin
          in_if.valid <= 1'b0;
          in_on = 1'b0;
        end
        repeat (gap) @(posedge clk);
      end
    end
    in_if.valid   <= 1'b1;
    in_if.op      <= op;
    in_if.rx_byte <= b;
    in_on = 1'b1;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    reply_q.push_back(predict_reply(op, b));
    items_sent++;
    burst_left--;
  endtask

  // Sends the first 'upto' words of a block; a full block is BLOCK_WORDS words.
  task automatic send_block(input logic [7:0] num, input logic [7:0] inv, input int upto,
                            input bit bad_sum, input int tick_pct);
    logic [7:0] sum;
    logic [7:0] d;
    int i;
    sum = '0;
    send_word(OP_BYTE, CODE_SOH);
    for (i = 1; i < upto; i++) begin
      if ($urandom_range(0, 99) < tick_pct) send_word(OP_TICK, 8'($urandom));
      if (i == 1) begin
        d = num;
      end else if (i == 2) begin
        d = inv;
      end else if (i < BLOCK_WORDS - 1) begin
        d = (i == 3) ? 8'h00 : (i == 4) ? 8'hff : 8'($urandom);
        sum = sum + d;
      end else begin
        d = bad_sum ? (sum ^ (8'd1 << $urandom_range(0, 7))) : sum;
      end
      send_word(OP_BYTE, d);
    end
  endtask

  task automatic send_good_block(input int tick_pct);
    send_block(exp_block, exp_block ^ INV_MASK, BLOCK_WORDS, 1'b0, tick_pct);
  endtask

  task automatic wait_replies_drained();
    if (in_on) begin
      in_if.valid <= 1'b0;
      in_on = 1'b0;
    end
    burst_left = 0;
    @(posedge clk);
    while (reply_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_nak_interval(input logic [23:0] v);
    wait_replies_drained();
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= v;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    nak_ivl = v;
    cfg_if.valid <= 1'b0;
  endtask

  task automatic test_start_requests();
    // At the reset interval a few ticks draw no NAK; the unused op changes nothing.
    repeat (5) send_word(OP_TICK, 8'hff);
    send_word(OP_UNUSED, 8'h00);
    // Lowering the interval below the running count: the next tick requests a NAK.
    set_nak_interval(24'd3);
    send_word(OP_TICK, 8'h00);
    // A stray byte before the first SOH clears the count.
    send_word(OP_TICK, 8'h00);
    send_word(OP_BYTE, 8'h55);
    repeat (3) send_word(OP_TICK, 8'h00);
    set_nak_interval(24'd1);
    repeat (2) send_word(OP_TICK, 8'h00);
    set_nak_interval(24'd0);
    repeat (2) send_word(OP_TICK, 8'h00);
    set_nak_interval(24'hffffff);
    repeat (3) send_word(OP_TICK, 8'h00);
    // A restart clears the count but keeps the interval.
    set_nak_interval(24'd2);
    send_word(OP_TICK, 8'h00);
    send_word(OP_RESTART, 8'hff);
    repeat (2) send_word(OP_TICK, 8'h00);
  endtask

  task automatic test_block_exchange();
    set_nak_interval(24'd4);
    send_word(OP_RESTART, 8'h00);
    send_good_block(0);
    // A bad checksum is answered with NAK and the resent block overwrites the data.
    send_block(exp_block, exp_block ^ INV_MASK, BLOCK_WORDS, 1'b1, 0);
    send_good_block(20);
    // Repeated block number, then a wrong inverse.
    send_block(exp_block - 8'd1, 8'h00, 2, 1'b0, 0);
    send_block(exp_block, exp_block, 3, 1'b0, 0);
    send_good_block(0);
    send_word(OP_BYTE, CODE_EOT);
    // Once ended, ticks and bytes only repeat the status.
    send_word(OP_TICK, 8'h00);
    send_word(OP_BYTE, CODE_SOH);
    send_word(OP_RESTART, 8'h00);
  endtask

  task automatic test_transfer_endings();
    send_word(OP_BYTE, CODE_CAN);
    send_word(OP_TICK, 8'h00);
    send_word(OP_RESTART, 8'h00);
    send_word(OP_BYTE, CODE_EOT);
    send_word(OP_RESTART, 8'h00);
    // A stray byte after the first SOH is a protocol error.
    send_good_block(0);
    send_word(OP_BYTE, 8'h7f);
    send_word(OP_BYTE, CODE_EOT);
    send_word(OP_RESTART, 8'h00);
    send_good_block(0);
    send_word(OP_BYTE, CODE_CAN);
    send_word(OP_RESTART, 8'h00);
  endtask

  task automatic test_output_stall();
    // The receiver holds off while the sender keeps offering words.
    hold_req = 400;
    send_good_block(10);
    send_good_block(0);
    send_word(OP_BYTE, CODE_EOT);
    send_word(OP_RESTART, 8'h00);
  endtask

  task automatic test_random_sessions(input int target);
    int start_cnt;
    int nblk;
    int kind;
    int i;
    logic [7:0] b;
    start_cnt = items_sent;
    while (items_sent - start_cnt < target) begin
      case ($urandom_range(0, 9))
        0:       set_nak_interval(24'd1);
        1:       set_nak_interval(24'hffffff);
        default: set_nak_interval(24'($urandom_range(2, 12)));
      endcase
      send_word(OP_RESTART, 8'($urandom));
      repeat ($urandom_range(0, 20)) send_word(OP_TICK, 8'($urandom));
      if ($urandom_range(0, 3) == 0) begin
        b = 8'($urandom);
        if (b == CODE_SOH || b == CODE_EOT || b == CODE_CAN) b = b ^ 8'h80;
        send_word(OP_BYTE, b);
        repeat ($urandom_range(0, 6)) send_word(OP_TICK, 8'($urandom));
      end
      nblk = $urandom_range(0, 4);
      for (i = 0; i < nblk && rx_phase != PH_DONE; i++) begin
        kind = $urandom_range(0, 99);
        if (kind < 62) begin
          send_good_block(8);
        end else if (kind < 74) begin
          send_block(exp_block, exp_block ^ INV_MASK, BLOCK_WORDS, 1'b1, 8);
        end else if (kind < 82) begin
          send_block(exp_block + 8'($urandom_range(1, 255)), 8'h00, 2, 1'b0, 0);
        end else if (kind < 89) begin
          send_block(exp_block, exp_block ^ INV_MASK ^ 8'($urandom_range(1, 255)), 3,
                     1'b0, 0);
        end else if (kind < 94) begin
          send_block(exp_block, exp_block ^ INV_MASK, $urandom_range(4, BLOCK_WORDS - 1),
                     1'b0, 0);
        end else begin
          send_word(2'($urandom_range(0, 2)), 8'($urandom));
        end
      end
      case ($urandom_range(0, 5))
        0, 1: send_word(OP_BYTE, CODE_EOT);
        2:    send_word(OP_BYTE, CODE_CAN);
        default: ;
      endcase
      repeat ($urandom_range(0, 3)) send_word(2'($urandom_range(0, 1)), 8'($urandom));
    end
  endtask

  // Result checker: each accepted word is compared with the oldest prediction.
  always @(posedge clk) begin : check_replies
    reply_t got;
    reply_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      got.send_valid  = out_if.send_valid;
      got.send_byte   = out_if.send_byte;
      got.write_valid = out_if.write_valid;
      got.write_addr  = out_if.write_addr;
      got.write_data  = out_if.write_data;
      got.status      = out_if.status;
      got.size_total  = out_if.size_total;
      replies_seen++;
      if (got.send_valid && got.send_byte == CODE_ACK) ack_seen++;
      if (got.send_valid && got.send_byte == CODE_NAK) nak_seen++;
      if (got.write_valid) wr_seen++;
      if (reply_q.size() == 0) begin
        err_count++;
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS)
          $display("tb: %0t unexpected result word: %s", $realtime, fmt_reply(got));
      end else begin
        want = reply_q.pop_front();
        if (got !== want) begin
          err_count++;
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORTS) begin
            $display("tb: %0t mismatch on result word %0d", $realtime, replies_seen);
            $display("tb:   expected %s", fmt_reply(want));
            $display("tb:   actual   %s", fmt_reply(got));
          end
        end
      end
    end
  end

  // Receiver stalls on its own pattern, with an optional long hold-off.
  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_left  = $urandom_range(20, 150);
    end
    mode_left--;
    pattern_cnt++;
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      case (stall_mode)
        0:       out_if.ready <= 1'b1;
        1:       out_if.ready <= ($urandom_range(0, 9) < 7);
        2:       out_if.ready <= ($urandom_range(0, 3) == 0);
        default: out_if.ready <= (pattern_cnt % 16 < 11);
      endcase
    end
  end

  // Watchdog: ends the run when no word moves on any channel for too long.
  always @(posedge clk) begin
    if (rst_n && in_if.valid && !in_if.ready) in_stall_cycles++;
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: no word accepted for %0d cycles", quiet_cycles);
      $display("tb: done, errors");
      $finish;
    end
  end

  initial begin
    in_if.valid   = 1'b0;
    in_if.op      = OP_TICK;
    in_if.rx_byte = 8'h00;
    out_if.ready  = 1'b0;
    cfg_if.valid  = 1'b0;
    cfg_if.data   = '0;
    nak_ivl       = NAK_INTERVAL_RST;
    clear_receiver();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_start_requests();
    test_block_exchange();
    test_transfer_endings();
    test_output_stall();
    test_random_sessions(100);

    wait_replies_drained();
    repeat (4) @(posedge clk);
    $display("tb: %0d words sent, %0d result words checked (%0d ACK, %0d NAK, %0d writes)",
             items_sent, replies_seen, ack_seen, nak_seen, wr_seen);
    $display("tb: start NAK timing, block errors, endings, output stall; %0d input stall cycles",
             in_stall_cycles);
    if (err_count == 0 && reply_q.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
